/* hdl/cda_pkg.sv */
package cda_pkg;

  // Field widths
  localparam int MONTH_W        = 4;
  localparam int DAY_W          = 5;
  localparam int YEAR_W         = 12;
  localparam int DOY_W          = 9;
  localparam int KIND_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;
  localparam int DAYS_WIDTH_DEF = 16;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 2'd1;

  // Reset values
  localparam logic [YEAR_W-1:0]  RST_MIN_YEAR = 12'd1500;
  localparam logic [YEAR_W-1:0]  RST_MAX_YEAR = 12'd2017;
  localparam logic [MONTH_W-1:0] RST_MONTH    = 4'd1;
  localparam logic [DAY_W-1:0]   RST_DAY      = 5'd1;
  localparam logic [YEAR_W-1:0]  RST_YEAR     = 12'd1500;

  localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;
  localparam logic [MONTH_W-1:0] LAST_MONTH  = 4'd12;

  // Divisibility by 25 through the modular inverse of 25 mod 2^12
  localparam logic [YEAR_W-1:0] INV25   = 12'd3113;
  localparam logic [YEAR_W-1:0] LIM25   = 12'd163;

  localparam logic [DOY_W-1:0] LEN_COMMON = 9'd365;
  localparam logic [DOY_W-1:0] LEN_LEAP   = 9'd366;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load_commit;
    logic add_init;
    logic year_step;
    logic month_step;
    logic add_commit;
    logic use_work;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [KIND_W-1:0] in_kind;
    logic              load_ok;
    logic              year_more;
    logic              year_ovf;
    logic              year_in;
    logic              month_more;
  } sts_t;

  // Gregorian leap test: divisible by 4 and not by 100, or by 400
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV25};
    div25 = (prod[YEAR_W-1:0] <= LIM25);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [DOY_W-1:0] year_len(input logic leap);
    return leap ? LEN_LEAP : LEN_COMMON;
  endfunction

  // Days in a month; months outside 1..12 count as 31
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] n;
    case (m) inside
      4'd2:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  // Days in the year before the first of a month
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Day of the year; a month outside 1..12 is taken as January
  function automatic logic [DOY_W-1:0] day_of_year(input logic [MONTH_W-1:0] m,
                                                   input logic [DAY_W-1:0]   d,
                                                   input logic               leap);
    logic past_feb;
    past_feb = (m > 4'd2) && (m <= LAST_MONTH) && leap;
    return cum_days(m) + {{(DOY_W-DAY_W){1'b0}}, d} + {{(DOY_W-1){1'b0}}, past_feb};
  endfunction

endpackage

/* hdl/cda_if.sv */
interface cda_in_if #(
  parameter int DaysWidth = cda_pkg::DAYS_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [3:0]           new_month;
  logic [4:0]           new_day;
  logic [11:0]          new_year;
  logic [DaysWidth-1:0] add_days;

  modport source (output valid, kind, new_month, new_day, new_year, add_days,
                  input ready);
  modport sink   (input valid, kind, new_month, new_day, new_year, add_days,
                  output ready);
endinterface

interface cda_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [11:0] cur_year;
  logic [8:0]  day_of_year;
  logic [8:0]  days_left;
  logic        accepted;

  modport source (output valid, cur_month, cur_day, cur_year, day_of_year, days_left,
                  accepted, input ready);
  modport sink   (input valid, cur_month, cur_day, cur_year, day_of_year, days_left,
                  accepted, output ready);
endinterface

/* hdl/cda_ctrl.sv */
module cda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cda_pkg::sts_t sts_i,
  output cda_pkg::cmd_t cmd_o
);
  import cda_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_INIT   = 3'd2;
  localparam logic [2:0] S_YEAR   = 3'd3;
  localparam logic [2:0] S_MONTH  = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Sequence one request at a time
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (sts_i.in_kind)
            KIND_LOAD: state_d = S_LOAD;
            KIND_ADD:  state_d = S_INIT;
            default:   state_d = S_REPORT;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_commit = sts_i.load_ok;
        state_d           = S_REPORT;
      end
      S_INIT: begin
        cmd_o.add_init = 1'b1;
        state_d        = S_YEAR;
      end
      S_YEAR: begin
        cmd_o.use_work = 1'b1;
        if (sts_i.year_more) begin
          cmd_o.year_step = 1'b1;
          // drop the add once the year passes the upper limit
          if (sts_i.year_ovf) state_d = S_REPORT;
        end else if (sts_i.year_in) begin
          state_d = S_MONTH;
        end else begin
          state_d = S_REPORT;
        end
      end
      S_MONTH: begin
        cmd_o.use_work = 1'b1;
        if (sts_i.month_more) begin
          cmd_o.month_step = 1'b1;
        end else begin
          cmd_o.add_commit = 1'b1;
          state_d          = S_REPORT;
        end
      end
      S_REPORT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until the consumer takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/cda_dpath.sv */
module cda_dpath #(
  parameter int DaysWidth = cda_pkg::DAYS_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cda_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cda_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [cda_pkg::KIND_W-1:0]       kind_i,
  input  logic [cda_pkg::MONTH_W-1:0]      new_month_i,
  input  logic [cda_pkg::DAY_W-1:0]        new_day_i,
  input  logic [cda_pkg::YEAR_W-1:0]       new_year_i,
  input  logic [DaysWidth-1:0]             add_days_i,
  input  cda_pkg::cmd_t                    cmd_i,
  output cda_pkg::sts_t                    sts_o,
  output logic [cda_pkg::MONTH_W-1:0]      cur_month_o,
  output logic [cda_pkg::DAY_W-1:0]        cur_day_o,
  output logic [cda_pkg::YEAR_W-1:0]       cur_year_o,
  output logic [cda_pkg::DOY_W-1:0]        day_of_year_o,
  output logic [cda_pkg::DOY_W-1:0]        days_left_o,
  output logic                             accepted_o
);
  import cda_pkg::*;

  // Running total holds a day of the year plus the full day count
  localparam int TotW = ((DaysWidth > DOY_W) ? DaysWidth : DOY_W) + 1;

  logic [YEAR_W-1:0]    min_q, max_q;
  logic [MONTH_W-1:0]   month_q;
  logic [DAY_W-1:0]     day_q;
  logic [YEAR_W-1:0]    year_q;
  logic                 ok_q;
  logic [MONTH_W-1:0]   nm_q;
  logic [DAY_W-1:0]     nd_q;
  logic [YEAR_W-1:0]    ny_q;
  logic [DaysWidth-1:0] add_q;
  logic [YEAR_W-1:0]    wy_q;
  logic [MONTH_W-1:0]   wm_q;
  logic [TotW-1:0]      tot_q;

  logic [MONTH_W-1:0]   out_month_q;
  logic [DAY_W-1:0]     out_day_q;
  logic [YEAR_W-1:0]    out_year_q;
  logic [DOY_W-1:0]     out_doy_q;
  logic [DOY_W-1:0]     out_left_q;
  logic                 out_ok_q;

  logic                 leap;
  logic [DOY_W-1:0]     ylen;
  logic [DAY_W-1:0]     mlen;
  logic [DOY_W-1:0]     doy_cur;
  logic [DOY_W-1:0]     left_cur;
  logic [YEAR_W:0]      wy_next;

  // Share one leap test between the stored date and the working year
  assign leap     = is_leap(cmd_i.use_work ? wy_q : year_q);
  assign ylen     = year_len(leap);
  assign mlen     = month_len(wm_q, leap);
  assign doy_cur  = day_of_year(month_q, day_q, leap);
  assign left_cur = (doy_cur <= ylen) ? (ylen - doy_cur) : '0;
  assign wy_next  = {1'b0, wy_q} + {{YEAR_W{1'b0}}, 1'b1};

  // Status for the controller
  always_comb begin
    sts_o.in_kind    = kind_i;
    sts_o.load_ok    = (nm_q >= FIRST_MONTH) && (nm_q <= LAST_MONTH) &&
                       (nd_q != '0) && (ny_q >= min_q) && (ny_q <= max_q);
    sts_o.year_more  = (tot_q > TotW'(ylen));
    sts_o.year_ovf   = (wy_next > {1'b0, max_q});
    sts_o.year_in    = (wy_q >= min_q) && (wy_q <= max_q);
    sts_o.month_more = (wm_q != LAST_MONTH) && (tot_q > TotW'(mlen));
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= RST_MIN_YEAR;
      max_q <= RST_MAX_YEAR;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_YEAR: min_q <= cfg_data_i;
        REG_MAX_YEAR: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stored date and request outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q <= RST_MONTH;
      day_q   <= RST_DAY;
      year_q  <= RST_YEAR;
      ok_q    <= 1'b0;
    end else begin
      if (cmd_i.capture) ok_q <= 1'b0;
      if (cmd_i.load_commit) begin
        month_q <= nm_q;
        day_q   <= nd_q;
        year_q  <= ny_q;
        ok_q    <= 1'b1;
      end else if (cmd_i.add_commit) begin
        month_q <= wm_q;
        day_q   <= tot_q[DAY_W-1:0];
        year_q  <= wy_q;
        ok_q    <= 1'b1;
      end
    end
  end

  // Capture the request and walk years, then months
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      nm_q  <= new_month_i;
      nd_q  <= new_day_i;
      ny_q  <= new_year_i;
      add_q <= add_days_i;
    end
    if (cmd_i.add_init) begin
      wy_q  <= year_q;
      wm_q  <= FIRST_MONTH;
      tot_q <= TotW'(doy_cur) + TotW'(add_q);
    end else if (cmd_i.year_step) begin
      wy_q  <= wy_next[YEAR_W-1:0];
      tot_q <= tot_q - TotW'(ylen);
    end else if (cmd_i.month_step) begin
      wm_q  <= wm_q + FIRST_MONTH;
      tot_q <= tot_q - TotW'(mlen);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_month_q <= month_q;
      out_day_q   <= day_q;
      out_year_q  <= year_q;
      out_doy_q   <= doy_cur;
      out_left_q  <= left_cur;
      out_ok_q    <= ok_q;
    end
  end

  assign cur_month_o   = out_month_q;
  assign cur_day_o     = out_day_q;
  assign cur_year_o    = out_year_q;
  assign day_of_year_o = out_doy_q;
  assign days_left_o   = out_left_q;
  assign accepted_o    = out_ok_q;

endmodule

/* hdl/calendar_date_adder_unit.sv */
// Calendar date adder: holds one Gregorian date and takes one request at a time.
// A load (kind 0) checks and stores a new date, an add (kind 1) moves the date
// forward by add_days, and any other kind only reports. Every request returns
// one result with the stored date, its day of the year, the days left in the
// year and an accepted flag. An add walks whole years, about add_days / 365 and up
// to 180 for a 16-bit count, one year per cycle, and then months, at most 11. A
// waiting result sits in an output register, so the next request is accepted while
// it is still pending. The user must write min_year and max_year through the config
// port only while no request is in progress; the block does not enforce this.
module calendar_date_adder_unit #(
  parameter int DaysWidth = cda_pkg::DAYS_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cda_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cda_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cda_in_if.sink                         in_if,
  cda_out_if.source                      out_if
);
  import cda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cda_dpath #(
    .DaysWidth (DaysWidth)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (in_if.kind),
    .new_month_i   (in_if.new_month),
    .new_day_i     (in_if.new_day),
    .new_year_i    (in_if.new_year),
    .add_days_i    (in_if.add_days),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cur_month_o   (out_if.cur_month),
    .cur_day_o     (out_if.cur_day),
    .cur_year_o    (out_if.cur_year),
    .day_of_year_o (out_if.day_of_year),
    .days_left_o   (out_if.days_left),
    .accepted_o    (out_if.accepted)
  );

endmodule

/* hdl/cda_checker.sv */
module cda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] cur_month_i,
  input logic [4:0] cur_day_i,
  input logic [8:0] day_of_year_i,
  input logic [8:0] days_left_i
);

  // Hold a pending result until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // Take one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while another is in progress");

  // Report a real date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cur_month_i >= 4'd1) && (cur_month_i <= 4'd12) && (cur_day_i != 5'd0))
    else $error("reported date out of range");

  // Day of the year and days left cover the whole year
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ({1'b0, day_of_year_i} + {1'b0, days_left_i} == 10'd365) ||
                    ({1'b0, day_of_year_i} + {1'b0, days_left_i} == 10'd366))
    else $error("day of year and days left do not add up to a year");

endmodule

bind calendar_date_adder_unit cda_checker u_cda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .cur_month_i   (out_if.cur_month),
  .cur_day_i     (out_if.cur_day),
  .day_of_year_i (out_if.day_of_year),
  .days_left_i   (out_if.days_left)
);
